@@ rtl/dtb_pkg.sv @@
// ----------------------------------------------------------------------------
// dtb_pkg: shared types and constants for the datetime text to BCD clock
// Character codes, item layouts, status codes and the text position decode.
// ----------------------------------------------------------------------------
package dtb_pkg;

  // text layout
  localparam int unsigned TextLen   = 19;
  localparam int unsigned NumDigits = 14;
  localparam int unsigned NumSeps   = 5;
  localparam int unsigned PosW      = 5;
  localparam int unsigned DigitIdxW = 4;
  localparam int unsigned SepIdxW   = 3;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // separator slots
  localparam logic [SepIdxW-1:0] SEP_DATE_HI = 3'd0;
  localparam logic [SepIdxW-1:0] SEP_DATE_LO = 3'd1;
  localparam logic [SepIdxW-1:0] SEP_MID     = 3'd2;
  localparam logic [SepIdxW-1:0] SEP_TIME_HI = 3'd3;
  localparam logic [SepIdxW-1:0] SEP_TIME_LO = 3'd4;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FORMAT  = 2'd1,
    ST_CENTURY = 2'd2,
    ST_DATE    = 2'd3
  } status_e;

  // input item
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  // result item
  typedef struct packed {
    status_e    status;
    logic [6:0] sec_bcd;
    logic [6:0] min_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] day_bcd;
    logic [7:0] month_cent_bcd;
    logic [7:0] year_bcd;
  } res_item_t;

  // what a text position holds: a digit slot or a separator slot
  typedef struct packed {
    logic                 is_sep;
    logic [DigitIdxW-1:0] slot;
  } pos_info_t;

  function automatic pos_info_t pos_decode(input logic [PosW-1:0] pos);
    pos_info_t info;
    info = '0;
    unique case (pos)
      5'd0:  info = '{is_sep: 1'b0, slot: 4'd0};
      5'd1:  info = '{is_sep: 1'b0, slot: 4'd1};
      5'd2:  info = '{is_sep: 1'b0, slot: 4'd2};
      5'd3:  info = '{is_sep: 1'b0, slot: 4'd3};
      5'd4:  info = '{is_sep: 1'b1, slot: {1'b0, SEP_DATE_HI}};
      5'd5:  info = '{is_sep: 1'b0, slot: 4'd4};
      5'd6:  info = '{is_sep: 1'b0, slot: 4'd5};
      5'd7:  info = '{is_sep: 1'b1, slot: {1'b0, SEP_DATE_LO}};
      5'd8:  info = '{is_sep: 1'b0, slot: 4'd6};
      5'd9:  info = '{is_sep: 1'b0, slot: 4'd7};
      5'd10: info = '{is_sep: 1'b1, slot: {1'b0, SEP_MID}};
      5'd11: info = '{is_sep: 1'b0, slot: 4'd8};
      5'd12: info = '{is_sep: 1'b0, slot: 4'd9};
      5'd13: info = '{is_sep: 1'b1, slot: {1'b0, SEP_TIME_HI}};
      5'd14: info = '{is_sep: 1'b0, slot: 4'd10};
      5'd15: info = '{is_sep: 1'b0, slot: 4'd11};
      5'd16: info = '{is_sep: 1'b1, slot: {1'b0, SEP_TIME_LO}};
      5'd17: info = '{is_sep: 1'b0, slot: 4'd12};
      5'd18: info = '{is_sep: 1'b0, slot: 4'd13};
      default: info = '0;
    endcase
    return info;
  endfunction

  // expected character of each separator slot
  function automatic logic [7:0] sep_expect(input logic [SepIdxW-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      SEP_DATE_HI, SEP_DATE_LO: c = CH_DASH;
      SEP_MID:                  c = CH_SPACE;
      SEP_TIME_HI, SEP_TIME_LO: c = CH_COLON;
      default:                  c = 8'h00;
    endcase
    return c;
  endfunction

  // binary value of a two digit pair
  function automatic logic [6:0] pair_val(input logic [3:0] tens, input logic [3:0] units);
    return 7'({3'b000, tens} * 7'd10 + {3'b000, units});
  endfunction

endpackage

@@ rtl/dtb_stream_if.sv @@
// ----------------------------------------------------------------------------
// dtb_stream_if: valid/ready channel
// Carries one item per handshake; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface dtb_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/datetime_text_to_bcd_clock_top.sv @@
// ----------------------------------------------------------------------------
// datetime_text_to_bcd_clock_top: datetime text to BCD clock registers
// Parses "CCYY-MM-DD hh:mm:ss" one character per item and checks it.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one character per item (ch, last); the item with last set
//   closes the text. Characters beyond the 19th are dropped, missing ones
//   count as NUL. out_o carries one result item per text: a status and the
//   BCD clock bytes, all zero on any error status.
// Throughput: one character per cycle while out_o does not hold off results,
//   including back to back texts. Each character is merged from its input
//   register into the digit and separator masks.
// Result path: the result for a text passes from the input register through
//   the text snapshot register to the result register; the date check sits
//   between the last two.
// Reset: clears the position counter, the masks and every valid flag; the
//   digit store itself is not cleared, its entries are only read when seen.
// Stall: while out_o is held off, the snapshot and result registers hold;
//   characters without last keep flowing, a last character waits in the
//   input register and in_i.ready drops until the snapshot stage frees.
// ----------------------------------------------------------------------------
module datetime_text_to_bcd_clock_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  dtb_stream_if.sink        in_i,
  dtb_stream_if.source      out_o
);
  import dtb_pkg::*;

  // input register
  logic       in_v_q;
  logic [7:0] in_ch_q;
  logic       in_last_q;

  // text state
  logic [PosW-1:0]      pos_q, pos_d;
  logic [3:0]           store_q [NumDigits];
  logic [3:0]           store_d [NumDigits];
  logic [NumDigits-1:0] seen_q, seen_d;
  logic [NumSeps-1:0]   sep_q, sep_d;

  // text snapshot
  logic                 frame_v_q;
  logic [3:0]           fdig_q [NumDigits];
  logic [NumDigits-1:0] fseen_q;
  logic [NumSeps-1:0]   fsep_q;

  // result register
  logic      out_v_q;
  res_item_t out_q;
  res_item_t res_d;

  // flow control
  logic in_adv, frame_mv, frame_rdy;
  assign frame_mv  = frame_v_q && (!out_v_q || out_o.ready);
  assign frame_rdy = !frame_v_q || frame_mv;
  assign in_adv    = in_v_q && (!in_last_q || frame_rdy);
  assign in_i.ready  = !in_v_q || in_adv;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_ch_q   <= in_i.data.ch;
      in_last_q <= in_i.data.last;
    end
  end

  // merge the current character into the text state
  pos_info_t  pinfo;
  logic       is_digit;
  logic [7:0] ch_diff;
  always_comb begin
    pinfo    = pos_decode(pos_q);
    is_digit = (in_ch_q >= CH_ZERO) && (in_ch_q <= CH_NINE);
    ch_diff  = in_ch_q - CH_ZERO;
    pos_d    = pos_q;
    seen_d   = seen_q;
    sep_d    = sep_q;
    store_d  = store_q;
    if (pos_q < PosW'(TextLen)) begin
      pos_d = pos_q + 1'b1;
      if (pinfo.is_sep) begin
        sep_d[pinfo.slot[SepIdxW-1:0]] =
          (in_ch_q == sep_expect(pinfo.slot[SepIdxW-1:0]));
      end else begin
        seen_d[pinfo.slot] = is_digit;
        if (is_digit) begin
          store_d[pinfo.slot] = ch_diff[3:0];
        end
      end
    end
  end

  // text state and snapshot control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      seen_q    <= '0;
      sep_q     <= '0;
      frame_v_q <= 1'b0;
    end else begin
      if (in_adv) begin
        if (in_last_q) begin
          pos_q  <= '0;
          seen_q <= '0;
          sep_q  <= '0;
        end else begin
          pos_q  <= pos_d;
          seen_q <= seen_d;
          sep_q  <= sep_d;
        end
      end
      frame_v_q <= (frame_v_q && !frame_mv) || (in_adv && in_last_q);
    end
  end

  // digit store and snapshot payload
  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      store_q <= store_d;
      if (in_last_q) begin
        fdig_q  <= store_d;
        fseen_q <= seen_d;
        fsep_q  <= sep_d;
      end
    end
  end

  // pair values and validity
  logic [6:0] cent_v, year_v, mon_v, day_v, hour_v, min_v, sec_v;
  logic       cent_ok, all_pairs, ranges_ok, leap, date_ok, cent21;
  always_comb begin
    cent_v = pair_val(fdig_q[0],  fdig_q[1]);
    year_v = pair_val(fdig_q[2],  fdig_q[3]);
    mon_v  = pair_val(fdig_q[4],  fdig_q[5]);
    day_v  = pair_val(fdig_q[6],  fdig_q[7]);
    hour_v = pair_val(fdig_q[8],  fdig_q[9]);
    min_v  = pair_val(fdig_q[10], fdig_q[11]);
    sec_v  = pair_val(fdig_q[12], fdig_q[13]);

    cent21  = (cent_v == 7'd21);
    cent_ok = fseen_q[0] && fseen_q[1] && ((cent_v == 7'd20) || cent21);
    all_pairs = &fseen_q;
    ranges_ok = (day_v >= 7'd1) && (day_v <= 7'd31) &&
                (mon_v >= 7'd1) && (mon_v <= 7'd12) &&
                (hour_v <= 7'd23) && (min_v <= 7'd59) && (sec_v <= 7'd59);
    // gregorian rule on 100*century+year, century limited to 20 or 21
    leap = (year_v[1:0] == 2'b00) && ((year_v != 7'd0) || !cent21);

    priority if (day_v < 7'd29) begin
      date_ok = 1'b1;
    end else if (mon_v != 7'd2) begin
      date_ok = (day_v < 7'd31) ||
                (mon_v == 7'd1) || (mon_v == 7'd3) || (mon_v == 7'd5) ||
                (mon_v == 7'd7) || (mon_v == 7'd8) || (mon_v == 7'd10) ||
                (mon_v == 7'd12);
    end else if (day_v > 7'd29) begin
      date_ok = 1'b0;
    end else begin
      date_ok = leap;
    end

    res_d = '0;
    priority if (fsep_q != {NumSeps{1'b1}}) begin
      res_d.status = ST_FORMAT;
    end else if (!cent_ok) begin
      res_d.status = ST_CENTURY;
    end else if (!(all_pairs && ranges_ok && date_ok)) begin
      res_d.status = ST_DATE;
    end else begin
      res_d.status         = ST_OK;
      res_d.sec_bcd        = {fdig_q[12][2:0], fdig_q[13]};
      res_d.min_bcd        = {fdig_q[10][2:0], fdig_q[11]};
      res_d.hour_bcd       = {fdig_q[8][1:0],  fdig_q[9]};
      res_d.day_bcd        = {fdig_q[6][1:0],  fdig_q[7]};
      res_d.month_cent_bcd = {cent21, 2'b00, fdig_q[4][0], fdig_q[5]};
      res_d.year_bcd       = {fdig_q[2], fdig_q[3]};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= (out_v_q && !out_o.ready) || frame_mv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_mv) begin
      out_q <= res_d;
    end
  end

  // checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(TextLen))
    else $error("text position past end");

  a_last_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv && in_last_q |=> frame_v_q)
    else $error("closing character did not reach snapshot");

  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_adv && in_last_q |=> (pos_q == '0) && (seen_q == '0) && (sep_q == '0))
    else $error("text state not cleared after closing character");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.status != ST_OK) |->
      (out_q.sec_bcd == '0) && (out_q.min_bcd == '0) && (out_q.hour_bcd == '0) &&
      (out_q.day_bcd == '0) && (out_q.month_cent_bcd == '0) && (out_q.year_bcd == '0))
    else $error("error result carries clock bytes");

  a_ok_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.status == ST_OK) |->
      (out_q.hour_bcd[5:4] != 2'b11) && (out_q.month_cent_bcd[6:5] == 2'b00))
    else $error("ok result with impossible hour or month byte");

endmodule
